// File: rtl/core/image_orientation_address_gen_assert.svh
// assertion macros for the orientation address generator
`ifndef IMAGE_ORIENTATION_ADDRESS_GEN_ASSERT_SVH
`define IMAGE_ORIENTATION_ADDRESS_GEN_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define IOAG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ioag assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define IOAG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ioag assertion failed");
`else
`define IOAG_ASSERT_IMPL(label, ante, cons)
`define IOAG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/ioag_pkg.sv
// shared types, constants and helpers for the orientation address generator
`timescale 1ns / 1ps
`default_nettype none
package ioag_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = 13;
    localparam int CNT_W         = $clog2(MAX_DIMENSION);
    localparam int BPP_W         = 3;
    localparam int PIX_W         = 32;
    localparam int IDX_W         = 24;
    localparam int ADDR_W        = 26;
    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 32;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIMENSION);

    // register indexes
    localparam logic [2:0] REG_WIDTH     = 3'd0;
    localparam logic [2:0] REG_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_BPP       = 3'd2;
    localparam logic [2:0] REG_CORNER    = 3'd3;
    localparam logic [2:0] REG_TRANSPOSE = 3'd4;

    // where source top-left lands when transpose is off
    localparam logic [1:0] CORNER_UL = 2'd0;
    localparam logic [1:0] CORNER_LL = 2'd1;
    localparam logic [1:0] CORNER_LR = 2'd2;
    localparam logic [1:0] CORNER_UR = 2'd3;

    // effective configuration, already clamped
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [BPP_W-1:0] bpp;
        logic [1:0]       corner;
        logic             transpose;
    } cfg_t;

    // one word between the index stage and the address stage
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [IDX_W-1:0] idx;
        logic             last;
    } stage_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_MAX)
        begin
            r = DIM_MAX;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [BPP_W-1:0] clamp_bpp(input logic [BPP_W-1:0] v);
        logic [BPP_W-1:0] r;
        if (v == '0)
        begin
            r = BPP_W'(1);
        end
        else if (v > BPP_W'(4))
        begin
            r = BPP_W'(4);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // index times 1..4 by shift and add
    function automatic logic [ADDR_W-1:0] byte_offset(input logic [IDX_W-1:0] idx,
                                                      input logic [BPP_W-1:0] bpp);
        logic [ADDR_W-1:0] x;
        logic [ADDR_W-1:0] r;
        x = ADDR_W'(idx);
        case (bpp)
            BPP_W'(2): r = x << 1;
            BPP_W'(3): r = x + (x << 1);
            BPP_W'(4): r = x << 2;
            default:   r = x;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/ioag_cfg.sv
// register file on the apb port, with clamped values and frame restart
`timescale 1ns / 1ps
`default_nettype none
module ioag_cfg
    import ioag_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg,
    output logic                    restart
);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [BPP_W-1:0] bpp_reg;
    logic [1:0]       corner_reg;
    logic             transpose_reg;
    logic [2:0]       reg_idx;
    logic             wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr      = psel & penable & pwrite;

    always_comb
    begin
        restart = 1'b0;
        case (reg_idx)
            REG_WIDTH, REG_HEIGHT, REG_BPP, REG_CORNER, REG_TRANSPOSE: restart = wr;
            default: restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= DIM_W'(1);
            height_reg    <= DIM_W'(1);
            bpp_reg       <= BPP_W'(4);
            corner_reg    <= CORNER_UL;
            transpose_reg <= 1'b0;
        end
        else if (wr)
        begin
            case (reg_idx)
                REG_WIDTH:     width_reg     <= pwdata[DIM_W-1:0];
                REG_HEIGHT:    height_reg    <= pwdata[DIM_W-1:0];
                REG_BPP:       bpp_reg       <= pwdata[BPP_W-1:0];
                REG_CORNER:    corner_reg    <= pwdata[1:0];
                REG_TRANSPOSE: transpose_reg <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WIDTH:     prdata = PDATA_W'(width_reg);
            REG_HEIGHT:    prdata = PDATA_W'(height_reg);
            REG_BPP:       prdata = PDATA_W'(bpp_reg);
            REG_CORNER:    prdata = PDATA_W'(corner_reg);
            REG_TRANSPOSE: prdata = PDATA_W'(transpose_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.width     = clamp_dim(width_reg);
    assign cfg.height    = clamp_dim(height_reg);
    assign cfg.bpp       = clamp_bpp(bpp_reg);
    assign cfg.corner    = corner_reg;
    assign cfg.transpose = transpose_reg;

endmodule
`default_nettype wire

// File: rtl/core/ioag_map.sv
// raster counters and destination index stage
`timescale 1ns / 1ps
`default_nettype none
module ioag_map
    import ioag_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             restart,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [PIX_W-1:0] pixel_value,
    input  wire logic             s2_ready,
    output logic                  s1_valid,
    output stage_t                s1_word
);

    logic [CNT_W-1:0]       col_reg;
    logic [CNT_W-1:0]       row_reg;
    logic                   s1_valid_reg;
    stage_t                 s1_reg;
    logic                   accept;
    logic [DIM_W-1:0]       col_plus;
    logic [DIM_W-1:0]       row_plus;
    logic                   end_row;
    logic                   last;
    logic [CNT_W-1:0]       col_inv;
    logic [CNT_W-1:0]       row_inv;
    logic [CNT_W-1:0]       dst_row;
    logic [CNT_W-1:0]       dst_col;
    logic [DIM_W-1:0]       dst_width;
    logic [CNT_W+DIM_W-1:0] prod;
    logic [IDX_W-1:0]       dest_pointer;

    assign in_stall = s1_valid_reg & ~s2_ready;
    assign accept   = in_valid & ~in_stall;

    assign col_plus = {1'b0, col_reg} + DIM_W'(1);
    assign row_plus = {1'b0, row_reg} + DIM_W'(1);
    assign end_row  = col_plus >= cfg.width;
    assign last     = end_row & (row_plus >= cfg.height);

    // mirrored coordinates
    assign col_inv = CNT_W'(cfg.width - DIM_W'(1) - {1'b0, col_reg});
    assign row_inv = CNT_W'(cfg.height - DIM_W'(1) - {1'b0, row_reg});

    always_comb
    begin
        dst_width = cfg.transpose ? cfg.height : cfg.width;
        if (!cfg.transpose)
        begin
            case (cfg.corner)
                CORNER_UL: begin dst_row = row_reg; dst_col = col_reg; end
                CORNER_LL: begin dst_row = row_inv; dst_col = col_reg; end
                CORNER_LR: begin dst_row = row_inv; dst_col = col_inv; end
                default:   begin dst_row = row_reg; dst_col = col_inv; end
            endcase
        end
        else
        begin
            case (cfg.corner)
                CORNER_UL: begin dst_row = col_inv; dst_col = row_inv; end
                CORNER_LL: begin dst_row = col_reg; dst_col = row_inv; end
                CORNER_LR: begin dst_row = col_reg; dst_col = row_reg; end
                default:   begin dst_row = col_inv; dst_col = row_reg; end
            endcase
        end
    end

    assign prod         = {{DIM_W{1'b0}}, dst_row} * {{CNT_W{1'b0}}, dst_width};
    assign dest_pointer = IDX_W'(prod + (CNT_W + DIM_W)'(dst_col));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                if (end_row)
                begin
                    col_reg <= '0;
                    row_reg <= last ? '0 : row_plus[CNT_W-1:0];
                end
                else
                begin
                    col_reg <= col_plus[CNT_W-1:0];
                end
            end
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.pixel <= pixel_value;
            s1_reg.idx   <= dest_pointer;
            s1_reg.last  <= last;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_word  = s1_reg;

`include "image_orientation_address_gen_assert.svh"
    `IOAG_ASSERT_IMPL(a_col_in_frame, 1'b1, {1'b0, col_reg} < cfg.width)
    `IOAG_ASSERT_IMPL(a_row_in_frame, 1'b1, {1'b0, row_reg} < cfg.height)
    `IOAG_ASSERT_NEXT(a_wrap_after_last, accept && last, col_reg == '0 && row_reg == '0)

endmodule
`default_nettype wire

// File: rtl/core/ioag_out.sv
// byte address stage and output register
`timescale 1ns / 1ps
`default_nettype none
module ioag_out
    import ioag_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              s1_valid,
    input  wire stage_t            s1_word,
    output logic                   s2_ready,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [PIX_W-1:0]       pixel_out,
    output logic [IDX_W-1:0]       dest_index,
    output logic [ADDR_W-1:0]      dest_byte_address,
    output logic                   frame_last
);

    logic              out_valid_reg;
    logic [PIX_W-1:0]  pixel_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              last_reg;

    assign s2_ready = ~out_valid_reg | ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid)
        begin
            pixel_reg <= s1_word.pixel;
            idx_reg   <= s1_word.idx;
            addr_reg  <= byte_offset(s1_word.idx, cfg.bpp);
            last_reg  <= s1_word.last;
        end
    end

    assign out_valid         = out_valid_reg;
    assign pixel_out         = pixel_reg;
    assign dest_index        = idx_reg;
    assign dest_byte_address = addr_reg;
    assign frame_last        = last_reg;

endmodule
`default_nettype wire

// File: rtl/core/image_orientation_address_gen.sv
// top level of the image orientation address generator
// Takes source pixels in raster order, one word per clock unless out_stall holds
// the pipe, and gives for each one its destination pixel index and byte address
// under one of eight orientations (corner code 0..3, with or without transpose).
// Throughput is one word per cycle sustained while out_stall is low. Each word
// passes two register stages: the first holds the index multiply (destination
// row times destination width), the second the byte address (index times bytes
// per pixel by shift and add). A write to any mapped register restarts the
// frame at the first pixel; writes to unmapped slots are ignored. Width and
// height of 0 act as 1 and above 4096 act as 4096; bytes per pixel 0 acts as 1
// and above 4 acts as 4.
`timescale 1ns / 1ps
`default_nettype none
module image_orientation_address_gen
    import ioag_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    // source pixel words
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [PIX_W-1:0]   pixel_value,
    // result words
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [PIX_W-1:0]        pixel_out,
    output logic [IDX_W-1:0]        dest_index,
    output logic [ADDR_W-1:0]       dest_byte_address,
    output logic                    frame_last
);

    cfg_t   cfg;
    logic   restart;
    logic   s1_valid;
    stage_t s1_word;
    logic   s2_ready;

    // registers, clamping, restart pulse on any write to a mapped register
    ioag_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .restart (restart)
    );

    // column and row counters, destination index per accepted word
    ioag_map u_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .restart     (restart),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_value (pixel_value),
        .s2_ready    (s2_ready),
        .s1_valid    (s1_valid),
        .s1_word     (s1_word)
    );

    // byte address and the output register
    ioag_out u_out (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .s1_valid          (s1_valid),
        .s1_word           (s1_word),
        .s2_ready          (s2_ready),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .pixel_out         (pixel_out),
        .dest_index        (dest_index),
        .dest_byte_address (dest_byte_address),
        .frame_last        (frame_last)
    );

`include "image_orientation_address_gen_assert.svh"
    // input only backs up when both stages are full
    `IOAG_ASSERT_IMPL(a_stall_only_when_full, in_stall, out_valid && s1_valid)

endmodule
`default_nettype wire

// File: tb/tb_image_orientation_address_gen.sv
// testbench for the image orientation address generator: self-checking, random stream with stalls
`timescale 1ns / 1ps
module tb_image_orientation_address_gen;
    import ioag_pkg::*;

    // run sizing
    localparam int ITEM_TARGET    = 1850;
    localparam int QUIET_TAIL     = 250;   // last words run with no idling at all
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word moving on either side
    localparam int SETTLE_CYCLES  = 4;     // two-stage pipe plus margin

    // register slots past the end of the map; writes there must be ignored
    localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

    // one expected result word
    typedef struct {
        logic [PIX_W-1:0]  pixel;
        logic [IDX_W-1:0]  index;
        logic [ADDR_W-1:0] address;
        logic              last;
    } dest_word_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    // dut connections, every input known from time zero
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic [PIX_W-1:0]   pixel_value = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [PIX_W-1:0]   pixel_out;
    logic [IDX_W-1:0]   dest_index;
    logic [ADDR_W-1:0]  dest_byte_address;
    logic               frame_last;

    image_orientation_address_gen i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .pixel_value       (pixel_value),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .pixel_out         (pixel_out),
        .dest_index        (dest_index),
        .dest_byte_address (dest_byte_address),
        .frame_last        (frame_last)
    );

    // shared between the stimulus thread, driver and monitor
    logic [PIX_W-1:0] pending_pixels[$];  // source words not yet put on the bus
    dest_word_t       expected_words[$];  // predictions waiting for their result word
    int               idle_pct     = 0;   // chance of starting an idle burst, per side
    int               error_count  = 0;
    int               words_sent   = 0;
    int               frame_ends   = 0;
    int               settings_run = 0;
    int               quiet_cycles = 0;

    // ------------------------------------------------------------------
    // orientation predictor: its own copy of registers and frame position
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] cfg_width;
    logic [DIM_W-1:0] cfg_height;
    logic [BPP_W-1:0] cfg_bpp;
    logic [1:0]       cfg_corner;
    logic             cfg_transpose;
    int unsigned      src_col;
    int unsigned      src_row;
    logic [IDX_W-1:0] next_dest_index;

    // zero acts as one, anything past the maximum saturates
    function automatic int unsigned effective_dim(input logic [DIM_W-1:0] v);
        if (v == 0)
        begin
            return 1;
        end
        if (int'(v) > MAX_DIMENSION)
        begin
            return MAX_DIMENSION;
        end
        return int'(v);
    endfunction

    function automatic int unsigned effective_bpp(input logic [BPP_W-1:0] v);
        if (v == 0)
        begin
            return 1;
        end
        if (v > 4)
        begin
            return 4;
        end
        return int'(v);
    endfunction

    // destination index of source pixel (c, r) under the current orientation
    function automatic logic [IDX_W-1:0] oriented_index(input int unsigned c,
                                                        input int unsigned r);
        longint unsigned w;
        longint unsigned h;
        longint unsigned row;
        longint unsigned col;
        longint unsigned dest_w;
        w = effective_dim(cfg_width);
        h = effective_dim(cfg_height);
        if (!cfg_transpose)
        begin
            // destination keeps the source shape
            dest_w = w;
            case (cfg_corner)
                CORNER_UL: begin row = r;         col = c;         end
                CORNER_LL: begin row = h - 1 - r; col = c;         end
                CORNER_LR: begin row = h - 1 - r; col = w - 1 - c; end
                default:   begin row = r;         col = w - 1 - c; end
            endcase
        end
        else
        begin
            // destination is h wide and w tall
            dest_w = h;
            case (cfg_corner)
                CORNER_UL: begin row = w - 1 - c; col = h - 1 - r; end
                CORNER_LL: begin row = c;         col = h - 1 - r; end
                CORNER_LR: begin row = c;         col = r;         end
                default:   begin row = w - 1 - c; col = r;         end
            endcase
        end
        return IDX_W'(row * dest_w + col);
    endfunction

    function automatic void restart_frame_model();
        src_col         = 0;
        src_row         = 0;
        next_dest_index = oriented_index(0, 0);
    endfunction

    // any write to a mapped register restarts the frame; spare slots do nothing
    function automatic void apply_register(input logic [2:0] idx,
                                           input logic [PDATA_W-1:0] data);
        bit mapped;
        mapped = 1'b1;
        case (idx)
            REG_WIDTH:     cfg_width     = data[DIM_W-1:0];
            REG_HEIGHT:    cfg_height    = data[DIM_W-1:0];
            REG_BPP:       cfg_bpp       = data[BPP_W-1:0];
            REG_CORNER:    cfg_corner    = data[1:0];
            REG_TRANSPOSE: cfg_transpose = data[0];
            default:       mapped        = 1'b0;
        endcase
        if (mapped)
        begin
            restart_frame_model();
        end
    endfunction

    function automatic void reset_model();
        cfg_width     = DIM_W'(1);
        cfg_height    = DIM_W'(1);
        cfg_bpp       = BPP_W'(4);
        cfg_corner    = CORNER_UL;
        cfg_transpose = 1'b0;
        restart_frame_model();
    endfunction

    // result word for one accepted source pixel, then step the raster position
    function automatic dest_word_t predict_dest_word(input logic [PIX_W-1:0] pix);
        dest_word_t  res;
        int unsigned w;
        int unsigned h;
        bit          end_row;
        bit          last;
        w       = effective_dim(cfg_width);
        h       = effective_dim(cfg_height);
        end_row = (src_col + 1 >= w);
        last    = end_row && (src_row + 1 >= h);
        res.pixel   = pix;
        res.index   = next_dest_index;
        res.address = ADDR_W'(longint'(next_dest_index) * effective_bpp(cfg_bpp));
        res.last    = last;
        if (end_row)
        begin
            src_col = 0;
            src_row = last ? 0 : src_row + 1;
        end
        else
        begin
            src_col = src_col + 1;
        end
        next_dest_index = oriented_index(src_col, src_row);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // source driver: pops pending pixels, idles in bursts, holds while stalled
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            // word taken at this edge: predict its result now
            if (in_valid && !in_stall)
            begin
                expected_words.push_back(predict_dest_word(pixel_value));
            end
            // the bus is free to change only when nothing is held
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0 && idle_pct != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_pixels.size() != 0)
                begin
                    in_valid    <= 1'b1;
                    pixel_value <= pending_pixels.pop_front();
                    if ($urandom_range(99) < idle_pct)
                    begin
                        gap_left <= $urandom_range(1, 18);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and receiver back-pressure
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk)
    begin
        dest_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected: dest_index %0d", dest_index);
                    error_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (pixel_out !== want.pixel)
                    begin
                        $error("pixel_out expected %h actual %h", want.pixel, pixel_out);
                        error_count++;
                    end
                    if (dest_index !== want.index)
                    begin
                        $error("dest_index expected %0d actual %0d", want.index, dest_index);
                        error_count++;
                    end
                    if (dest_byte_address !== want.address)
                    begin
                        $error("dest_byte_address expected %0d actual %0d",
                               want.address, dest_byte_address);
                        error_count++;
                    end
                    if (frame_last !== want.last)
                    begin
                        $error("frame_last expected %b actual %b", want.last, frame_last);
                        error_count++;
                    end
                    if (want.last)
                    begin
                        frame_ends++;
                    end
                end
            end
            // stall in random bursts, independent of out_valid
            if (stall_left > 0 && idle_pct != 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if ($urandom_range(99) < idle_pct)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 17);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog: nothing moving for too long means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[image_orientation_address_gen] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus sequencing
    // ------------------------------------------------------------------

    // apb write: setup cycle, access cycle, register lands at the access edge
    task automatic reg_write(input logic [2:0] idx, input logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_register(idx, data);
    endtask

    // sometimes set junk above the field so the register masking gets exercised
    function automatic logic [PDATA_W-1:0] with_junk(input int unsigned value,
                                                     input int field_w);
        if ($urandom_range(3) == 0)
        begin
            return PDATA_W'(value) | PDATA_W'($urandom() << field_w);
        end
        return PDATA_W'(value);
    endfunction

    task automatic write_setting(input int unsigned w, input int unsigned h,
                                 input int unsigned bpp, input logic [1:0] corner,
                                 input logic transp);
        reg_write(REG_WIDTH, PDATA_W'(w));
        reg_write(REG_HEIGHT, PDATA_W'(h));
        reg_write(REG_BPP, PDATA_W'(bpp));
        reg_write(REG_CORNER, PDATA_W'(corner));
        reg_write(REG_TRANSPOSE, PDATA_W'(transp));
        settings_run++;
    endtask

    // block until every word has gone in and every result has come out
    task automatic wait_drained();
        @(negedge clk);
        while (pending_pixels.size() != 0 || in_valid || expected_words.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_pixels(input int count);
        @(negedge clk);
        for (int i = 0; i < count; i++)
        begin
            pending_pixels.push_back($urandom());
        end
        words_sent += count;
        wait_drained();
    endtask

    // mostly small frames so they wrap often; a few odd or huge sizes
    function automatic int unsigned pick_dim();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
        begin
            return $urandom_range(1, 8);
        end
        if (sel < 85)
        begin
            return $urandom_range(9, 64);
        end
        if (sel < 90)
        begin
            return 0;
        end
        if (sel < 95)
        begin
            return $urandom_range(MAX_DIMENSION + 1, (1 << DIM_W) - 1);
        end
        return $urandom_range(65, MAX_DIMENSION);
    endfunction

    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned span;
        logic [2:0]  orient;
        int          phase;
        int          count;

        reset_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part ---

        // reset defaults: 1x1 frame, 4 bytes per pixel, every word ends a frame
        @(negedge clk);
        pending_pixels.push_back('0);
        pending_pixels.push_back('1);
        words_sent += 2;
        wait_drained();

        // largest frame turned 180 degrees: first pixel lands on the top index
        write_setting(MAX_DIMENSION, MAX_DIMENSION, 4, CORNER_LR, 1'b0);
        send_pixels(2);
        reg_write(REG_BPP, PDATA_W'(3));
        send_pixels(1);
        // anti-transpose of the largest frame hits the same corner
        reg_write(REG_CORNER, PDATA_W'(CORNER_UL));
        reg_write(REG_TRANSPOSE, PDATA_W'(1));
        send_pixels(2);

        // zero width, height and pixel size all act as one
        write_setting(0, 0, 0, CORNER_LL, 1'b1);
        send_pixels(2);

        // oversized dimensions saturate, pixel size above four acts as four
        write_setting((1 << DIM_W) - 1, 5000, 7, CORNER_UR, 1'b0);
        send_pixels(2);

        // a write in the middle of a frame starts it over
        write_setting(3, 2, 2, CORNER_LL, 1'b0);
        send_pixels(4);
        reg_write(REG_CORNER, PDATA_W'(CORNER_LL));
        send_pixels(3);

        // writes to unmapped slots leave the frame position alone
        send_pixels(2);
        reg_write(REG_SPARE_FIRST, '1);
        reg_write(REG_SPARE_LAST, '1);
        send_pixels(5);

        // --- random part ---
        phase = 0;
        while (words_sent < ITEM_TARGET)
        begin
            // first eight settings walk every orientation in turn
            orient = (phase < 8) ? 3'(phase) : 3'($urandom_range(7));
            phase++;
            w = pick_dim();
            h = pick_dim();
            if (words_sent > ITEM_TARGET - QUIET_TAIL)
            begin
                idle_pct = 0;
            end
            else
            begin
                case ($urandom_range(3))
                    0:       idle_pct = 0;
                    1:       idle_pct = 5;
                    2:       idle_pct = 20;
                    default: idle_pct = 50;
                endcase
            end
            if (phase > 8 && $urandom_range(3) == 0)
            begin
                // touch only the orientation, keep size and pixel width
                reg_write(REG_CORNER, with_junk(orient[1:0], 2));
                reg_write(REG_TRANSPOSE, with_junk(orient[2], 1));
                settings_run++;
            end
            else
            begin
                reg_write(REG_WIDTH, with_junk(w, DIM_W));
                reg_write(REG_HEIGHT, with_junk(h, DIM_W));
                reg_write(REG_BPP, with_junk($urandom_range(0, 7), BPP_W));
                reg_write(REG_CORNER, with_junk(orient[1:0], 2));
                reg_write(REG_TRANSPOSE, with_junk(orient[2], 1));
                settings_run++;
            end
            // two frames and three words at most, capped at 120, often stopping part way through
            span = effective_dim(cfg_width) * effective_dim(cfg_height) * 2 + 3;
            if (span > 120)
            begin
                span = 120;
            end
            count = $urandom_range(1, span);
            if ($urandom_range(9) == 0)
            begin
                reg_write(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom());
            end
            send_pixels(count);
        end

        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d pixel words under %0d register settings, %0d frame ends",
                 words_sent, settings_run, frame_ends);
        $display("all eight orientations, clamped sizes and mid-frame restarts included");
        if (error_count == 0 && expected_words.size() == 0)
        begin
            $display("[image_orientation_address_gen] OK");
        end
        else
        begin
            $display("[image_orientation_address_gen] ERROR");
        end
        $finish;
    end

endmodule
